// ===== hdl/ifrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrc_pkg
// Shared constants and types of the information frame receiver and checker.
// ----------------------------------------------------------------------------
package ifrc_pkg;

  localparam logic [7:0] FLAG_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_FLAG      = 8'h5E;
  localparam logic [7:0] ESC_ESC       = 8'h5D;
  localparam logic [7:0] ADDRESS_RESET = 8'h03;
  localparam logic [7:0] CTRL_RR       = 8'h05;
  localparam logic [7:0] CTRL_REJ      = 8'h01;
  localparam logic [7:0] CTRL_INFO0    = 8'h00;
  localparam logic [7:0] CTRL_INFO1    = 8'h40;

  localparam int PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_ADDRESS_BYTE = 2'd0;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_CTRL = 3'd2;
  localparam logic [2:0] PH_HCHK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] payload_byte;
    logic       frame_good;
    logic [7:0] reply_control;
    logic       frame_sequence;
  } result_t;

endpackage

// ===== hdl/ifrc_frame_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrc_frame_fsm
// Frame recognizer: header match, payload unstuffing, one-byte holdback,
// running XOR and end-of-frame verdict. Advances one line byte per step.
// ----------------------------------------------------------------------------
module ifrc_frame_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        address_byte,
  output ifrc_pkg::result_t result
);

  logic [2:0] phase, phase_next;
  logic       sequence_bit, sequence_bit_next;
  logic       escape_pending, escape_pending_next;
  logic       held_valid, held_valid_next;
  logic [7:0] held_byte, held_byte_next;
  logic [7:0] running_xor, running_xor_next;
  logic       frame_error, frame_error_next;

  logic       take_en;
  logic [7:0] take_byte;
  logic [7:0] ctrl_byte;
  logic       good;
  logic       nseq;

  always_comb begin
    phase_next          = phase;
    sequence_bit_next   = sequence_bit;
    escape_pending_next = escape_pending;
    held_valid_next     = held_valid;
    held_byte_next      = held_byte;
    running_xor_next    = running_xor;
    frame_error_next    = frame_error;
    take_en             = 1'b0;
    take_byte           = rx_byte;
    result              = '0;
    ctrl_byte           = sequence_bit ? ifrc_pkg::CTRL_INFO1 : ifrc_pkg::CTRL_INFO0;
    good                = held_valid && !frame_error && !escape_pending &&
                          (held_byte == running_xor);
    nseq                = ~sequence_bit;

    case (phase)
      ifrc_pkg::PH_ADDR: begin
        if (rx_byte == address_byte) begin
          phase_next = ifrc_pkg::PH_CTRL;
        end else if (rx_byte == ifrc_pkg::FLAG_BYTE) begin
          phase_next = ifrc_pkg::PH_ADDR;
        end else begin
          phase_next = ifrc_pkg::PH_WAIT;
        end
      end
      ifrc_pkg::PH_CTRL: begin
        if (rx_byte == ifrc_pkg::CTRL_INFO1) begin
          sequence_bit_next = 1'b1;
          phase_next        = ifrc_pkg::PH_HCHK;
        end else if (rx_byte == ifrc_pkg::CTRL_INFO0) begin
          sequence_bit_next = 1'b0;
          phase_next        = ifrc_pkg::PH_HCHK;
        end else if (rx_byte == ifrc_pkg::FLAG_BYTE) begin
          phase_next = ifrc_pkg::PH_ADDR;
        end else begin
          phase_next = ifrc_pkg::PH_WAIT;
        end
      end
      ifrc_pkg::PH_HCHK: begin
        if (rx_byte == (address_byte ^ ctrl_byte)) begin
          escape_pending_next = 1'b0;
          held_valid_next     = 1'b0;
          held_byte_next      = 8'h00;
          running_xor_next    = 8'h00;
          frame_error_next    = 1'b0;
          phase_next          = ifrc_pkg::PH_DATA;
        end else begin
          phase_next = ifrc_pkg::PH_WAIT;
        end
      end
      ifrc_pkg::PH_DATA: begin
        if (rx_byte == ifrc_pkg::FLAG_BYTE) begin
          result.valid          = 1'b1;
          result.kind           = ifrc_pkg::KIND_STATUS;
          result.frame_good     = good;
          result.reply_control  = (good ? ifrc_pkg::CTRL_RR : ifrc_pkg::CTRL_REJ) |
                                  {nseq, 7'd0};
          result.frame_sequence = sequence_bit;
          escape_pending_next   = 1'b0;
          held_valid_next       = 1'b0;
          held_byte_next        = 8'h00;
          running_xor_next      = 8'h00;
          frame_error_next      = 1'b0;
          phase_next            = ifrc_pkg::PH_WAIT;
        end else if (escape_pending) begin
          escape_pending_next = 1'b0;
          if (rx_byte == ifrc_pkg::ESC_FLAG) begin
            take_en   = 1'b1;
            take_byte = ifrc_pkg::FLAG_BYTE;
          end else if (rx_byte == ifrc_pkg::ESC_ESC) begin
            take_en   = 1'b1;
            take_byte = ifrc_pkg::ESC_BYTE;
          end else begin
            frame_error_next = 1'b1;
          end
        end else if (rx_byte == ifrc_pkg::ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else begin
          take_en = 1'b1;
        end
      end
      default: begin
        phase_next = (rx_byte == ifrc_pkg::FLAG_BYTE) ? ifrc_pkg::PH_ADDR
                                                       : ifrc_pkg::PH_WAIT;
      end
    endcase

    // emit the held byte, fold it in, hold the new one
    if (take_en) begin
      if (held_valid) begin
        result.valid          = 1'b1;
        result.kind           = ifrc_pkg::KIND_PAYLOAD;
        result.payload_byte   = held_byte;
        result.frame_sequence = sequence_bit;
        running_xor_next      = running_xor ^ held_byte;
      end
      held_byte_next  = take_byte;
      held_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ifrc_pkg::PH_WAIT;
      sequence_bit   <= 1'b0;
      escape_pending <= 1'b0;
      held_valid     <= 1'b0;
      held_byte      <= 8'h00;
      running_xor    <= 8'h00;
      frame_error    <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      sequence_bit   <= sequence_bit_next;
      escape_pending <= escape_pending_next;
      held_valid     <= held_valid_next;
      held_byte      <= held_byte_next;
      running_xor    <= running_xor_next;
      frame_error    <= frame_error_next;
    end
  end

endmodule

// ===== hdl/info_frame_receiver_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_receiver_checker
// A result beat is presented in the cycle after its line byte is taken.
// Throughput: one line byte per cycle; a new byte enters in the same cycle the
// last result is taken, so only a waiting result with out_ready low stalls.
// Reset (rst, synchronous): frame state cleared, waiting for an opening flag,
// address register back to 0x03, output register empty.
// ----------------------------------------------------------------------------
module info_frame_receiver_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ifrc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         result_kind,
  output logic [7:0]                   payload_byte,
  output logic                         frame_good,
  output logic [7:0]                   reply_control,
  output logic                         frame_sequence
);

  logic              [7:0] address_byte;
  logic                    step;
  ifrc_pkg::result_t       result;

  assign pready = 1'b1;
  assign prdata = (paddr == ifrc_pkg::REG_ADDRESS_BYTE) ? {24'd0, address_byte} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= ifrc_pkg::ADDRESS_RESET;
    end else if (psel && penable && pwrite && (paddr == ifrc_pkg::REG_ADDRESS_BYTE)) begin
      address_byte <= pwdata[7:0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  ifrc_frame_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (rx_byte),
    .address_byte (address_byte),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      result_kind    <= result.kind;
      payload_byte   <= result.payload_byte;
      frame_good     <= result.frame_good;
      reply_control  <= result.reply_control;
      frame_sequence <= result.frame_sequence;
    end
  end

endmodule
